// ===== hw/rtl/str_pkg.sv =====
// ---------------------------------------------------------------------------
// str_pkg: stepper trapezoid ramp package
// Field widths, operation and phase codes, register indexes and reset values
// shared by the ramp unit, its channels and its serial divider.
// ---------------------------------------------------------------------------
package str_pkg;

  localparam int PERIOD_BITS     = 16;
  localparam int ACCEL_BITS      = 8;
  localparam int STEP_TOTAL_BITS = 20;
  localparam int COUNT_BITS      = 20;
  localparam int OP_BITS         = 2;
  localparam int PHASE_BITS      = 2;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;
  localparam int DIV_STEPS       = PERIOD_BITS;
  localparam int DIV_CNT_BITS    = $clog2(DIV_STEPS);

  typedef logic [PERIOD_BITS-1:0]     period_t;
  typedef logic [ACCEL_BITS-1:0]      accel_t;
  typedef logic [STEP_TOTAL_BITS-1:0] step_total_t;
  typedef logic [COUNT_BITS-1:0]      count_t;
  typedef logic [OP_BITS-1:0]         op_t;
  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic [CFG_INDEX_BITS-1:0]  cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]   cfg_data_t;

  localparam count_t COUNT_MAX = '1;

  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_MOVE = 2'd1;
  localparam op_t OP_STOP = 2'd2;

  localparam phase_t PH_STOP = 2'd0;
  localparam phase_t PH_ACC  = 2'd1;
  localparam phase_t PH_PLAT = 2'd2;
  localparam phase_t PH_DEC  = 2'd3;

  localparam cfg_index_t REG_IDLE_PERIOD = 2'd0;
  localparam cfg_index_t REG_SPEED_LIMIT = 2'd1;
  localparam cfg_index_t REG_ACCEL_LIMIT = 2'd2;

  localparam period_t IDLE_PERIOD_RST = 16'd10000;
  localparam period_t SPEED_LIMIT_RST = 16'd9000;
  localparam accel_t  ACCEL_LIMIT_RST = 8'd100;

endpackage

// ===== hw/rtl/str_in_if.sv =====
// ---------------------------------------------------------------------------
// str_in_if: command channel
// Valid/ready channel carrying one tick, move or stop command per transfer.
// ---------------------------------------------------------------------------
interface str_in_if import str_pkg::*; ();
  logic        valid;
  logic        ready;
  op_t         operation;
  logic        direction;
  step_total_t step_total;
  period_t     speed;
  accel_t      accel;
  period_t     start_speed;

  modport source(output valid, output operation, output direction, output step_total,
                 output speed, output accel, output start_speed, input ready);
  modport sink(input valid, input operation, input direction, input step_total,
               input speed, input accel, input start_speed, output ready);
endinterface

// ===== hw/rtl/str_out_if.sv =====
// ---------------------------------------------------------------------------
// str_out_if: status channel
// Valid/ready channel carrying one status report per command.
// ---------------------------------------------------------------------------
interface str_out_if import str_pkg::*; ();
  logic    valid;
  logic    ready;
  period_t timer_period;
  phase_t  phase;
  logic    step_pulse;
  logic    running;
  logic    move_pending;
  logic    current_direction;

  modport source(output valid, output timer_period, output phase, output step_pulse,
                 output running, output move_pending, output current_direction,
                 input ready);
  modport sink(input valid, input timer_period, input phase, input step_pulse,
               input running, input move_pending, input current_direction,
               output ready);
endinterface

// ===== hw/rtl/str_cfg_if.sv =====
// ---------------------------------------------------------------------------
// str_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface str_cfg_if import str_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/str_div.sv =====
// ---------------------------------------------------------------------------
// str_div: serial period divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle
// with the quotient valid.
// ---------------------------------------------------------------------------
module str_div import str_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  period_t dividend,
  input  accel_t  divisor,
  output logic    done,
  output period_t quotient
);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  period_t                 quo_r, quo_nxt;
  accel_t                  rem_r, rem_nxt;
  accel_t                  dsr_r, dsr_nxt;
  logic [ACCEL_BITS:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[PERIOD_BITS-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = ACCEL_BITS'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[PERIOD_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = ACCEL_BITS'(trial);
        quo_nxt = {quo_r[PERIOD_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/stepper_trapezoid_ramp_unit.sv =====
// ---------------------------------------------------------------------------
// stepper_trapezoid_ramp_unit: trapezoidal step-period generator
// Tick, move and stop commands update the ramp state; a move that starts
// splits its step count with its serial divider.
// ---------------------------------------------------------------------------
// sequence: tick, stop and waiting moves pass S_OP, S_CTRL and S_DONE before the report is
//   registered; a move that starts passes S_OP, S_CTRL, S_PREP, S_DIV (serial divider), S_FIN, S_DONE
// throughput: one command at a time, the next is taken once the report is
//   registered; the report register lets the next command in while it waits
// reset: synchronous active-low rst_n clears the ramp state, stops the timer,
//   loads period 10000 and the register reset values; no clearing pass
module stepper_trapezoid_ramp_unit import str_pkg::*; #(
  parameter int STEP_COUNT_BITS = 20
) (
  input  logic   clk,
  input  logic   rst_n,
  str_in_if.sink     in_ch,
  str_out_if.source  out_ch,
  str_cfg_if.sink    cfg_ch
);

  localparam int SW = STEP_COUNT_BITS;
  localparam int CW = (SW > COUNT_BITS) ? SW : COUNT_BITS;

  typedef logic [SW-1:0] steps_t;
  typedef logic [CW-1:0] wide_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_OP   = 7'b0000010,
    S_CTRL = 7'b0000100,
    S_PREP = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  function automatic period_t sub_sat(period_t a, period_t b);
    return (a > b) ? period_t'(a - b) : '0;
  endfunction

  function automatic period_t add_sat(period_t a, accel_t b);
    logic [PERIOD_BITS:0] s;
    s = {1'b0, a} + (PERIOD_BITS + 1)'(b);
    return s[PERIOD_BITS] ? '1 : s[PERIOD_BITS-1:0];
  endfunction

  function automatic count_t cnt_inc(count_t c);
    return (c == COUNT_MAX) ? c : count_t'(c + 1'b1);
  endfunction

  state_t  state_r, state_nxt;

  // registers
  period_t idle_period_r;
  period_t speed_limit_r;
  accel_t  accel_limit_r;

  // latched command
  op_t         cmd_op_r;
  logic        cmd_dir_r;
  step_total_t cmd_steps_r;
  period_t     cmd_speed_r;
  accel_t      cmd_accel_r;
  period_t     cmd_start_r;

  // ramp state
  phase_t  run_phase_r, run_phase_nxt;
  phase_t  rep_phase_r, rep_phase_nxt;
  logic    move_dir_r, move_dir_nxt;
  steps_t  steps_left_r, steps_left_nxt;
  count_t  cnt_acc_r, cnt_acc_nxt;
  count_t  cnt_plat_r, cnt_plat_nxt;
  period_t ramp_lim_r, ramp_lim_nxt;
  steps_t  plat_lim_r, plat_lim_nxt;
  period_t period_r, period_nxt;
  period_t target_r, target_nxt;
  period_t start_period_r, start_period_nxt;
  accel_t  step_accel_r, step_accel_nxt;
  logic    slows_r, slows_nxt;
  logic    timer_on_r, timer_on_nxt;
  logic    rev_wait_r, rev_wait_nxt;
  logic    pulse_r, pulse_nxt;

  // pending move request
  logic    req_valid_r, req_valid_nxt;
  logic    req_dir_r, req_dir_nxt;
  steps_t  req_steps_r, req_steps_nxt;
  period_t req_speed_r, req_speed_nxt;
  accel_t  req_accel_r, req_accel_nxt;

  // report register
  logic    out_valid_r, out_valid_nxt;
  period_t out_period_r;
  phase_t  out_phase_r;
  logic    out_pulse_r;
  logic    out_running_r;
  logic    out_pending_r;
  logic    out_dir_r;

  logic    in_xfer;
  logic    rev_wait_now;
  period_t spd;
  accel_t  acc;
  count_t  cnt_acc_inc;
  count_t  cnt_plat_inc;
  period_t delta;
  logic    div_start;
  logic    div_done;
  period_t div_quo;
  logic [PERIOD_BITS:0] ramps;
  wide_t   plat_wide;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign div_start = (state_r == S_PREP);
  assign delta     = slows_nxt ? period_t'(target_r - period_r)
                               : period_t'(period_r - target_r);

  str_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (delta),
    .divisor  (step_accel_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_period_r <= IDLE_PERIOD_RST;
      speed_limit_r <= SPEED_LIMIT_RST;
      accel_limit_r <= ACCEL_LIMIT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_IDLE_PERIOD: idle_period_r <= cfg_ch.data;
        REG_SPEED_LIMIT: speed_limit_r <= cfg_ch.data;
        REG_ACCEL_LIMIT: accel_limit_r <= cfg_ch.data[ACCEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_op_r    <= in_ch.operation;
      cmd_dir_r   <= in_ch.direction;
      cmd_steps_r <= in_ch.step_total;
      cmd_speed_r <= in_ch.speed;
      cmd_accel_r <= in_ch.accel;
      cmd_start_r <= in_ch.start_speed;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    run_phase_nxt    = run_phase_r;
    rep_phase_nxt    = rep_phase_r;
    move_dir_nxt     = move_dir_r;
    steps_left_nxt   = steps_left_r;
    cnt_acc_nxt      = cnt_acc_r;
    cnt_plat_nxt     = cnt_plat_r;
    ramp_lim_nxt     = ramp_lim_r;
    plat_lim_nxt     = plat_lim_r;
    period_nxt       = period_r;
    target_nxt       = target_r;
    start_period_nxt = start_period_r;
    step_accel_nxt   = step_accel_r;
    slows_nxt        = slows_r;
    timer_on_nxt     = timer_on_r;
    rev_wait_nxt     = rev_wait_r;
    pulse_nxt        = pulse_r;
    req_valid_nxt    = req_valid_r;
    req_dir_nxt      = req_dir_r;
    req_steps_nxt    = req_steps_r;
    req_speed_nxt    = req_speed_r;
    req_accel_nxt    = req_accel_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;

    cnt_acc_inc  = cnt_inc(cnt_acc_r);
    cnt_plat_inc = cnt_inc(cnt_plat_r);
    rev_wait_now = rev_wait_r && (run_phase_r != PH_STOP);
    spd = (req_speed_r > speed_limit_r) ? speed_limit_r : req_speed_r;
    acc = (req_accel_r > accel_limit_r) ? accel_limit_r : req_accel_r;
    if (acc == '0) begin
      acc = ACCEL_BITS'(1);
    end
    ramps     = {1'b0, div_quo} + {1'b0, div_quo};
    plat_wide = (CW'(req_steps_r) > CW'(ramps)) ? wide_t'(CW'(req_steps_r) - CW'(ramps))
                                                : '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        pulse_nxt = 1'b0;
        unique case (cmd_op_r)
          OP_TICK: begin
            if (steps_left_r == '0) begin
              period_nxt    = start_period_r;
              timer_on_nxt  = 1'b0;
              run_phase_nxt = PH_STOP;
              rep_phase_nxt = PH_STOP;
            end else begin
              pulse_nxt      = 1'b1;
              steps_left_nxt = steps_left_r - 1'b1;
              priority if (run_phase_r == PH_ACC) begin
                rep_phase_nxt = PH_ACC;
                cnt_acc_nxt   = cnt_acc_inc;
                if (cnt_acc_inc >= COUNT_BITS'(ramp_lim_r)) begin
                  run_phase_nxt = PH_PLAT;
                end
                if (!slows_r) begin
                  period_nxt = (period_r > target_r) ? sub_sat(period_r, PERIOD_BITS'(step_accel_r))
                                                     : target_r;
                end else begin
                  period_nxt = (period_r < target_r) ? add_sat(period_r, step_accel_r)
                                                     : target_r;
                end
              end else if (run_phase_r == PH_PLAT) begin
                rep_phase_nxt = PH_PLAT;
                cnt_plat_nxt  = cnt_plat_inc;
                if (CW'(cnt_plat_inc) >= CW'(plat_lim_r)) begin
                  run_phase_nxt = PH_DEC;
                end
              end else begin
                rep_phase_nxt = PH_DEC;
                period_nxt = (period_r < idle_period_r) ? add_sat(period_r, step_accel_r)
                                                        : idle_period_r;
              end
            end
          end
          OP_MOVE: begin
            if (!req_valid_r) begin
              req_valid_nxt    = 1'b1;
              req_dir_nxt      = cmd_dir_r;
              req_steps_nxt    = SW'(cmd_steps_r);
              req_speed_nxt    = cmd_speed_r;
              req_accel_nxt    = cmd_accel_r;
              rep_phase_nxt    = PH_ACC;
              start_period_nxt = sub_sat(idle_period_r, cmd_start_r);
            end
          end
          OP_STOP: begin
            steps_left_nxt = '0;
          end
          default: ;
        endcase
        state_nxt = S_CTRL;
      end
      S_CTRL: begin
        rev_wait_nxt = rev_wait_now;
        if (rev_wait_now || !req_valid_r) begin
          state_nxt = S_DONE;
        end else if (run_phase_r == PH_STOP || req_dir_r == move_dir_r) begin
          step_accel_nxt = acc;
          target_nxt     = sub_sat(start_period_r, spd);
          state_nxt      = S_PREP;
        end else begin
          run_phase_nxt  = PH_DEC;
          steps_left_nxt = SW'(ramp_lim_r);
          rev_wait_nxt   = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_PREP: begin
        slows_nxt = (period_r < target_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        ramp_lim_nxt   = div_quo;
        plat_lim_nxt   = SW'(plat_wide);
        cnt_acc_nxt    = '0;
        cnt_plat_nxt   = '0;
        steps_left_nxt = req_steps_r;
        run_phase_nxt  = PH_ACC;
        move_dir_nxt   = req_dir_r;
        timer_on_nxt   = 1'b1;
        req_valid_nxt  = 1'b0;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      run_phase_r    <= PH_STOP;
      rep_phase_r    <= PH_STOP;
      move_dir_r     <= 1'b0;
      steps_left_r   <= '0;
      cnt_acc_r      <= '0;
      cnt_plat_r     <= '0;
      ramp_lim_r     <= '0;
      plat_lim_r     <= '0;
      period_r       <= IDLE_PERIOD_RST;
      target_r       <= '0;
      start_period_r <= '0;
      step_accel_r   <= '0;
      slows_r        <= 1'b0;
      timer_on_r     <= 1'b0;
      rev_wait_r     <= 1'b0;
      pulse_r        <= 1'b0;
      req_valid_r    <= 1'b0;
      req_dir_r      <= 1'b0;
      req_steps_r    <= '0;
      req_speed_r    <= '0;
      req_accel_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      run_phase_r    <= run_phase_nxt;
      rep_phase_r    <= rep_phase_nxt;
      move_dir_r     <= move_dir_nxt;
      steps_left_r   <= steps_left_nxt;
      cnt_acc_r      <= cnt_acc_nxt;
      cnt_plat_r     <= cnt_plat_nxt;
      ramp_lim_r     <= ramp_lim_nxt;
      plat_lim_r     <= plat_lim_nxt;
      period_r       <= period_nxt;
      target_r       <= target_nxt;
      start_period_r <= start_period_nxt;
      step_accel_r   <= step_accel_nxt;
      slows_r        <= slows_nxt;
      timer_on_r     <= timer_on_nxt;
      rev_wait_r     <= rev_wait_nxt;
      pulse_r        <= pulse_nxt;
      req_valid_r    <= req_valid_nxt;
      req_dir_r      <= req_dir_nxt;
      req_steps_r    <= req_steps_nxt;
      req_speed_r    <= req_speed_nxt;
      req_accel_r    <= req_accel_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // report capture
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_period_r  <= period_r;
      out_phase_r   <= rep_phase_r;
      out_pulse_r   <= pulse_r;
      out_running_r <= timer_on_r;
      out_pending_r <= req_valid_r;
      out_dir_r     <= move_dir_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.timer_period      = out_period_r;
  assign out_ch.phase             = out_phase_r;
  assign out_ch.step_pulse        = out_pulse_r;
  assign out_ch.running           = out_running_r;
  assign out_ch.move_pending      = out_pending_r;
  assign out_ch.current_direction = out_dir_r;

endmodule
